@@ sv/assert_macros.svh @@
// assertion macros shared by the selector rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/sgss_pkg.sv @@
// types, codes and constants for the solar/grid source selector
// no dependencies
`default_nettype none
package sgss_pkg;

   localparam int VAL_W = 12;
   localparam int EFF_W = 10;
   localparam int ACC_W = 15;
   localparam int IN_DATA_W = 56;
   localparam int OUT_DATA_W = 16;
   localparam int ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_DEGRADED = 2'd1,
      MODE_EMERGENCY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_SOLAR = 2'd1,
      SRC_GRID = 2'd2
   } source_type;

   typedef enum logic [2:0] {
      REG_AUTO_ENABLE = 3'd0,
      REG_SOLAR_VOLT_MIN = 3'd1,
      REG_SOLAR_VOLT_MAX = 3'd2,
      REG_SOLAR_CURR_MIN = 3'd3,
      REG_GRID_VOLT_MIN = 3'd4,
      REG_GRID_VOLT_MAX = 3'd5,
      REG_BONUS_VOLT = 3'd6,
      REG_TEMP_KNEE = 3'd7
   } reg_index_type;

   // register reset values
   localparam logic [VAL_W-1:0] RST_SOLAR_VOLT_MIN = 12'd120;
   localparam logic [VAL_W-1:0] RST_SOLAR_VOLT_MAX = 12'd220;
   localparam logic [VAL_W-1:0] RST_SOLAR_CURR_MIN = 12'd10;
   localparam logic [VAL_W-1:0] RST_GRID_VOLT_MIN = 12'd2000;
   localparam logic [VAL_W-1:0] RST_GRID_VOLT_MAX = 12'd2500;
   localparam logic [VAL_W-1:0] RST_BONUS_VOLT = 12'd130;
   localparam logic [VAL_W-1:0] RST_TEMP_KNEE = 12'd350;

   // efficiency figures, tenths of a percent
   localparam logic signed [ACC_W-1:0] EFF_SOLAR = 15'sd900;
   localparam logic signed [ACC_W-1:0] EFF_BONUS = 15'sd50;
   localparam logic signed [ACC_W-1:0] EFF_GRID = 15'sd750;
   localparam logic signed [ACC_W-1:0] EFF_MODE_PENALTY = 15'sd100;
   localparam logic signed [ACC_W-1:0] EFF_MAX = 15'sd1000;

   typedef struct packed {
      logic [VAL_W-1:0] solar_volts;
      logic [VAL_W-1:0] solar_amps;
      logic [VAL_W-1:0] grid_volts;
      logic solar_sensor_ok;
      logic grid_sensor_ok;
      logic critical_flag;
      logic signed [VAL_W-1:0] temperature;
   } sample_type;

   typedef struct packed {
      logic auto_enable;
      logic [VAL_W-1:0] solar_volt_min;
      logic [VAL_W-1:0] solar_volt_max;
      logic [VAL_W-1:0] solar_curr_min;
      logic [VAL_W-1:0] grid_volt_min;
      logic [VAL_W-1:0] grid_volt_max;
      logic [VAL_W-1:0] bonus_volt;
      logic signed [VAL_W-1:0] temp_knee;
   } cfg_type;

   typedef struct packed {
      logic solar_on;
      logic grid_on;
      source_type source;
   } relay_state_type;

   typedef struct packed {
      logic solar_relay;
      logic grid_relay;
      mode_type op_mode;
      source_type active_source;
      logic [EFF_W-1:0] efficiency;
   } result_type;

endpackage
`default_nettype wire

@@ sv/sgss_decide.sv @@
// mode, relay and efficiency decision for one sample word
// depends on sgss_pkg
`default_nettype none
module sgss_decide (
   input  sgss_pkg::sample_type      sample,
   input  sgss_pkg::cfg_type         cfg,
   input  sgss_pkg::relay_state_type state_cur,
   output sgss_pkg::relay_state_type state_nxt,
   output sgss_pkg::result_type      result
);
   import sgss_pkg::*;

   logic solar_viable;
   logic grid_viable;
   mode_type mode;
   logic drive;
   logic solar_tgt;
   logic grid_tgt;
   logic temp_hot;
   logic signed [VAL_W:0] temp_diff;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] penalty;
   logic signed [ACC_W-1:0] mode_pen;
   logic signed [ACC_W-1:0] eff_raw;

   // source viability windows
   assign solar_viable = sample.solar_sensor_ok
                         && (sample.solar_volts >= cfg.solar_volt_min)
                         && (sample.solar_volts <= cfg.solar_volt_max)
                         && (sample.solar_amps > cfg.solar_curr_min);
   assign grid_viable = sample.grid_sensor_ok
                        && (sample.grid_volts >= cfg.grid_volt_min)
                        && (sample.grid_volts <= cfg.grid_volt_max);

   // operating mode
   always_comb begin
      if (sample.critical_flag) begin
         mode = MODE_EMERGENCY;
      end else if (solar_viable && grid_viable) begin
         mode = MODE_NORMAL;
      end else if (grid_viable) begin
         mode = MODE_DEGRADED;
      end else begin
         mode = MODE_EMERGENCY;
      end
   end

   // relay targets; nothing moves while critical
   always_comb begin
      drive = 1'b0;
      solar_tgt = state_cur.solar_on;
      grid_tgt = state_cur.grid_on;
      if (!sample.critical_flag) begin
         if (mode == MODE_EMERGENCY) begin
            drive = 1'b1;
            solar_tgt = 1'b0;
            grid_tgt = grid_viable;
         end else if (cfg.auto_enable) begin
            drive = 1'b1;
            solar_tgt = (mode == MODE_NORMAL);
            grid_tgt = (mode != MODE_NORMAL);
         end
      end
   end

   // next relay state; a relay closing claims the source, grid over solar if both close
   always_comb begin
      state_nxt = state_cur;
      if (drive) begin
         state_nxt.solar_on = solar_tgt;
         state_nxt.grid_on = grid_tgt;
         if (solar_tgt && !state_cur.solar_on) begin
            state_nxt.source = SRC_SOLAR;
         end
         if (grid_tgt && !state_cur.grid_on) begin
            state_nxt.source = SRC_GRID;
         end
      end
   end

   // efficiency estimate for the updated state
   assign temp_diff = {sample.temperature[VAL_W-1], sample.temperature}
                      - {cfg.temp_knee[VAL_W-1], cfg.temp_knee};
   assign temp_hot = (sample.temperature > cfg.temp_knee);

   always_comb begin
      case (state_nxt.source)
         SRC_SOLAR: begin
            base = (sample.solar_volts >= cfg.bonus_volt) ? (EFF_SOLAR + EFF_BONUS)
                                                          : EFF_SOLAR;
         end
         SRC_GRID: begin
            base = EFF_GRID;
         end
         default: begin
            base = '0;
         end
      endcase
   end

   assign penalty = temp_hot ? {temp_diff[VAL_W], temp_diff, 1'b0} : '0;
   assign mode_pen = (mode != MODE_NORMAL) ? EFF_MODE_PENALTY : '0;
   assign eff_raw = base - penalty - mode_pen;

   // result word with clamp to 0..1000
   always_comb begin
      result.solar_relay = state_nxt.solar_on;
      result.grid_relay = state_nxt.grid_on;
      result.op_mode = mode;
      result.active_source = state_nxt.source;
      if (eff_raw < 0) begin
         result.efficiency = '0;
      end else if (eff_raw > EFF_MAX) begin
         result.efficiency = EFF_MAX[EFF_W-1:0];
      end else begin
         result.efficiency = eff_raw[EFF_W-1:0];
      end
   end

endmodule
`default_nettype wire

@@ sv/solar_grid_source_selector.sv @@
// a word accepted into the input register moves into the result register and leaves from there;
// throughput one word per cycle while the receiver takes result words without stalling
// the relay state register updates through the decision logic as each word advances
// reset is synchronous, active high: relays grid on / solar off, source grid,
// registers at their defaults, both pipeline stages empty
`default_nettype none
`include "assert_macros.svh"
module solar_grid_source_selector (
   input  wire logic clock,
   input  wire logic reset,
   // sample words
   input  wire logic req_tvalid,
   output logic req_tready,
   // solar_volts[11:0], solar_amps[23:12], grid_volts[35:24],
   // solar_sensor_ok[36], grid_sensor_ok[37], critical_flag[38],
   // temperature[50:39], zero[55:51]
   input  wire logic [sgss_pkg::IN_DATA_W-1:0] req_tdata,
   // result words
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // solar_relay[0], grid_relay[1], op_mode[3:2], active_source[5:4],
   // efficiency[15:6]
   output logic [sgss_pkg::OUT_DATA_W-1:0] rsp_tdata,
   // register port
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [sgss_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [sgss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sgss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import sgss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   relay_state_type state_ff;
   relay_state_type state_nxt;
   sample_type sample_ff;
   sample_type sample_in;
   logic in_valid_ff;
   logic in_valid_in;
   result_type result_nxt;
   result_type result_ff;
   logic out_valid_ff;
   logic out_valid_in;
   logic advance;
   logic csr_write;
   reg_index_type csr_index;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_AUTO_ENABLE:    cfg_in.auto_enable = csr_pwdata[0];
            REG_SOLAR_VOLT_MIN: cfg_in.solar_volt_min = csr_pwdata[VAL_W-1:0];
            REG_SOLAR_VOLT_MAX: cfg_in.solar_volt_max = csr_pwdata[VAL_W-1:0];
            REG_SOLAR_CURR_MIN: cfg_in.solar_curr_min = csr_pwdata[VAL_W-1:0];
            REG_GRID_VOLT_MIN:  cfg_in.grid_volt_min = csr_pwdata[VAL_W-1:0];
            REG_GRID_VOLT_MAX:  cfg_in.grid_volt_max = csr_pwdata[VAL_W-1:0];
            REG_BONUS_VOLT:     cfg_in.bonus_volt = csr_pwdata[VAL_W-1:0];
            REG_TEMP_KNEE:      cfg_in.temp_knee = csr_pwdata[VAL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_AUTO_ENABLE:    csr_prdata[0] = cfg_ff.auto_enable;
         REG_SOLAR_VOLT_MIN: csr_prdata[VAL_W-1:0] = cfg_ff.solar_volt_min;
         REG_SOLAR_VOLT_MAX: csr_prdata[VAL_W-1:0] = cfg_ff.solar_volt_max;
         REG_SOLAR_CURR_MIN: csr_prdata[VAL_W-1:0] = cfg_ff.solar_curr_min;
         REG_GRID_VOLT_MIN:  csr_prdata[VAL_W-1:0] = cfg_ff.grid_volt_min;
         REG_GRID_VOLT_MAX:  csr_prdata[VAL_W-1:0] = cfg_ff.grid_volt_max;
         REG_BONUS_VOLT:     csr_prdata[VAL_W-1:0] = cfg_ff.bonus_volt;
         REG_TEMP_KNEE:      csr_prdata[VAL_W-1:0] = cfg_ff.temp_knee;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable <= 1'b0;
         cfg_ff.solar_volt_min <= RST_SOLAR_VOLT_MIN;
         cfg_ff.solar_volt_max <= RST_SOLAR_VOLT_MAX;
         cfg_ff.solar_curr_min <= RST_SOLAR_CURR_MIN;
         cfg_ff.grid_volt_min <= RST_GRID_VOLT_MIN;
         cfg_ff.grid_volt_max <= RST_GRID_VOLT_MAX;
         cfg_ff.bonus_volt <= RST_BONUS_VOLT;
         cfg_ff.temp_knee <= RST_TEMP_KNEE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline handshake: the input stage moves on when the result slot frees
   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // unpack the incoming word
   always_comb begin
      sample_in.solar_volts = req_tdata[11:0];
      sample_in.solar_amps = req_tdata[23:12];
      sample_in.grid_volts = req_tdata[35:24];
      sample_in.solar_sensor_ok = req_tdata[36];
      sample_in.grid_sensor_ok = req_tdata[37];
      sample_in.critical_flag = req_tdata[38];
      sample_in.temperature = req_tdata[50:39];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= sample_in;
      end
   end

   sgss_decide u_decide (
      .sample    (sample_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (result_nxt)
   );

   // relay state follows each word as it moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.solar_on <= 1'b0;
         state_ff.grid_on <= 1'b1;
         state_ff.source <= SRC_GRID;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_nxt;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {result_ff.efficiency, result_ff.active_source, result_ff.op_mode,
                       result_ff.grid_relay, result_ff.solar_relay};

   // checks
   `ASSERT_ALWAYS(a_relays_exclusive, clock, reset, !(state_ff.solar_on && state_ff.grid_on))
   `ASSERT_ALWAYS(a_source_named, clock, reset, state_ff.source != SRC_NONE)
   `ASSERT_NEXT(a_critical_freeze, clock, reset, advance && sample_ff.critical_flag, $stable(state_ff))
   `ASSERT_ALWAYS(a_eff_range, clock, reset, !out_valid_ff || (result_ff.efficiency <= EFF_MAX[EFF_W-1:0]))
   `ASSERT_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(sample_ff))

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the solar/grid source selector: stream words in,
// result words out, registers over the csr port; needs sgss_pkg and the selector rtl
module testbench;
   import sgss_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 155;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // solar_volts[11:0], solar_amps[23:12], grid_volts[35:24], solar_sensor_ok[36],
   // grid_sensor_ok[37], critical_flag[38], temperature[50:39], zero[55:51]
   logic [IN_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // solar_relay[0], grid_relay[1], op_mode[3:2], active_source[5:4], efficiency[15:6]
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   solar_grid_source_selector dut (.*);

   // shadow copy of the registers and relay state
   cfg_type shadow_cfg;
   relay_state_type relay_state;
   result_type expected_selections[$];

   int mismatch_count = 0;
   int samples_sent = 0;
   int selections_seen = 0;
   int config_writes = 0;
   longint cycle_count = 0;

   // sender bursts and receiver stalls
   int burst_left = 0;
   int gap_max = 0;
   int burst_max = 40;
   int stall_pct = 0;
   int stall_max = 12;
   int stall_left = 0;

   always #6 clock = ~clock;

   function automatic cfg_type default_cfg();
      cfg_type c;
      c.auto_enable = 1'b0;
      c.solar_volt_min = RST_SOLAR_VOLT_MIN;
      c.solar_volt_max = RST_SOLAR_VOLT_MAX;
      c.solar_curr_min = RST_SOLAR_CURR_MIN;
      c.grid_volt_min = RST_GRID_VOLT_MIN;
      c.grid_volt_max = RST_GRID_VOLT_MAX;
      c.bonus_volt = RST_BONUS_VOLT;
      c.temp_knee = RST_TEMP_KNEE;
      return c;
   endfunction

   // mode decision, relay update and efficiency for one sample tick
   function automatic result_type select_source(input sample_type s);
      logic solar_ok, grid_ok, want_solar, want_grid, steer;
      mode_type mode;
      int eff, temp, knee;
      result_type r;
      solar_ok = s.solar_sensor_ok && s.solar_volts >= shadow_cfg.solar_volt_min
                 && s.solar_volts <= shadow_cfg.solar_volt_max
                 && s.solar_amps > shadow_cfg.solar_curr_min;
      grid_ok = s.grid_sensor_ok && s.grid_volts >= shadow_cfg.grid_volt_min
                && s.grid_volts <= shadow_cfg.grid_volt_max;
      if (s.critical_flag) mode = MODE_EMERGENCY;
      else if (solar_ok && grid_ok) mode = MODE_NORMAL;
      else if (grid_ok) mode = MODE_DEGRADED;
      else mode = MODE_EMERGENCY;

      // emergency rule always, auto rule when enabled, nothing moves while critical
      steer = !s.critical_flag && (mode == MODE_EMERGENCY || shadow_cfg.auto_enable);
      want_solar = (mode == MODE_NORMAL);
      want_grid = (mode == MODE_EMERGENCY) ? grid_ok : (mode == MODE_DEGRADED);
      if (steer) begin
         if (want_solar != relay_state.solar_on) begin
            relay_state.solar_on = want_solar;
            if (want_solar) relay_state.source = SRC_SOLAR;
         end
         if (want_grid != relay_state.grid_on) begin
            relay_state.grid_on = want_grid;
            if (want_grid) relay_state.source = SRC_GRID;
         end
      end

      // efficiency from the source after the update
      case (relay_state.source)
         SRC_SOLAR: eff = (s.solar_volts >= shadow_cfg.bonus_volt) ? 950 : 900;
         SRC_GRID: eff = 750;
         default: eff = 0;
      endcase
      temp = $signed(s.temperature);
      knee = $signed(shadow_cfg.temp_knee);
      if (temp > knee) eff -= 2 * (temp - knee);
      if (mode != MODE_NORMAL) eff -= 100;
      if (eff < 0) eff = 0;
      if (eff > 1000) eff = 1000;

      r.solar_relay = relay_state.solar_on;
      r.grid_relay = relay_state.grid_on;
      r.op_mode = mode;
      r.active_source = relay_state.source;
      r.efficiency = eff[EFF_W-1:0];
      return r;
   endfunction

   function automatic logic [IN_DATA_W-1:0] pack_sample(input sample_type s);
      return {5'd0, s.temperature, s.critical_flag, s.grid_sensor_ok, s.solar_sensor_ok,
              s.grid_volts, s.solar_amps, s.solar_volts};
   endfunction

   function automatic sample_type make_sample(input int sv, input int sa, input int gv,
                                              input bit sok, input bit gok, input bit crit,
                                              input int temp);
      sample_type s;
      s.solar_volts = sv[VAL_W-1:0];
      s.solar_amps = sa[VAL_W-1:0];
      s.grid_volts = gv[VAL_W-1:0];
      s.solar_sensor_ok = sok;
      s.grid_sensor_ok = gok;
      s.critical_flag = crit;
      s.temperature = temp[VAL_W-1:0];
      return s;
   endfunction

   // mostly inside the window, some on or just past an edge, some anywhere
   function automatic logic [VAL_W-1:0] pick_near(input logic [VAL_W-1:0] lo,
                                                  input logic [VAL_W-1:0] hi);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60 && lo <= hi) return VAL_W'($urandom_range(lo, hi));
      if (roll < 80) begin
         case ($urandom_range(0, 3))
            0: return lo - 12'd1;
            1: return lo;
            2: return hi;
            default: return hi + 12'd1;
         endcase
      end
      return VAL_W'($urandom());
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int roll, temp;
      s.solar_volts = pick_near(shadow_cfg.solar_volt_min, shadow_cfg.solar_volt_max);
      s.solar_amps = pick_near(shadow_cfg.solar_curr_min + 12'd1, 12'hFFF);
      s.grid_volts = pick_near(shadow_cfg.grid_volt_min, shadow_cfg.grid_volt_max);
      s.solar_sensor_ok = ($urandom_range(0, 9) != 0);
      s.grid_sensor_ok = ($urandom_range(0, 9) != 0);
      s.critical_flag = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 60) temp = int'($urandom_range(0, 1650)) - 400;
      else if (roll < 80) temp = $signed(shadow_cfg.temp_knee) + int'($urandom_range(0, 4)) - 2;
      else temp = $urandom();
      s.temperature = temp[VAL_W-1:0];
      return s;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      logic [VAL_W-1:0] a, b;
      c.auto_enable = 1'($urandom_range(0, 1));
      a = VAL_W'($urandom());
      b = VAL_W'($urandom());
      // windows mostly well ordered so that sources are sometimes viable
      c.solar_volt_min = (a <= b || $urandom_range(0, 3) == 0) ? a : b;
      c.solar_volt_max = (c.solar_volt_min == a) ? b : a;
      a = VAL_W'($urandom());
      b = VAL_W'($urandom());
      c.grid_volt_min = (a <= b || $urandom_range(0, 3) == 0) ? a : b;
      c.grid_volt_max = (c.grid_volt_min == a) ? b : a;
      c.solar_curr_min = $urandom_range(0, 3) == 0 ? VAL_W'($urandom())
                                                   : VAL_W'($urandom_range(0, 200));
      c.bonus_volt = VAL_W'($urandom());
      c.temp_knee = VAL_W'($urandom());
      return c;
   endfunction

   // profile bit 0: sender gaps, bit 1: receiver stalls
   task automatic set_pacing(input int profile);
      gap_max = profile[0] ? 6 : 0;
      burst_max = profile[0] ? 12 : 40;
      stall_pct = profile[1] ? 25 : 0;
      burst_left = 0;
   endtask

   // one sample word, with a random gap at the start of each burst
   task automatic send_sample(input sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= pack_sample(s);
      do @(posedge clock); while (!req_tready);
      expected_selections.push_back(select_source(s));
      samples_sent++;
      burst_left--;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [VAL_W-1:0] value);
      logic [CSR_DATA_W-1:0] noise, word;
      noise = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
      word = (idx == REG_AUTO_ENABLE) ? {noise[CSR_DATA_W-1:1], value[0]}
                                      : {noise[CSR_DATA_W-1:VAL_W], value};
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_AUTO_ENABLE: shadow_cfg.auto_enable = value[0];
         REG_SOLAR_VOLT_MIN: shadow_cfg.solar_volt_min = value;
         REG_SOLAR_VOLT_MAX: shadow_cfg.solar_volt_max = value;
         REG_SOLAR_CURR_MIN: shadow_cfg.solar_curr_min = value;
         REG_GRID_VOLT_MIN: shadow_cfg.grid_volt_min = value;
         REG_GRID_VOLT_MAX: shadow_cfg.grid_volt_max = value;
         REG_BONUS_VOLT: shadow_cfg.bonus_volt = value;
         REG_TEMP_KNEE: shadow_cfg.temp_knee = value;
         default: ;
      endcase
      config_writes++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_config(input cfg_type c);
      wait_idle();
      write_reg(REG_AUTO_ENABLE, {11'd0, c.auto_enable});
      write_reg(REG_SOLAR_VOLT_MIN, c.solar_volt_min);
      write_reg(REG_SOLAR_VOLT_MAX, c.solar_volt_max);
      write_reg(REG_SOLAR_CURR_MIN, c.solar_curr_min);
      write_reg(REG_GRID_VOLT_MIN, c.grid_volt_min);
      write_reg(REG_GRID_VOLT_MAX, c.grid_volt_max);
      write_reg(REG_BONUS_VOLT, c.bonus_volt);
      write_reg(REG_TEMP_KNEE, c.temp_knee);
   endtask

   // defaults after reset, auto off: only the emergency rule moves relays
   task automatic test_power_on_state();
      set_pacing(3);
      send_sample(make_sample(150, 100, 2300, 1, 1, 0, 250));
      send_sample(make_sample(150, 10, 2300, 1, 1, 0, 250));
      send_sample(make_sample(150, 100, 1500, 1, 1, 0, 250));
      send_sample(make_sample(150, 100, 2300, 1, 1, 0, 250));
   endtask

   // auto rule and the viability window edges
   task automatic test_auto_rules();
      cfg_type c;
      c = default_cfg();
      c.auto_enable = 1'b1;
      apply_config(c);
      set_pacing(1);
      send_sample(make_sample(150, 100, 2300, 1, 1, 0, 250));
      send_sample(make_sample(150, 10, 2300, 1, 1, 0, 250));
      send_sample(make_sample(120, 11, 2000, 1, 1, 0, 250));
      send_sample(make_sample(221, 11, 2500, 1, 1, 0, 250));
      send_sample(make_sample(220, 11, 2500, 1, 1, 0, 250));
      send_sample(make_sample(119, 50, 2200, 1, 1, 0, 250));
      send_sample(make_sample(150, 50, 2200, 0, 1, 0, 250));
      send_sample(make_sample(150, 50, 1999, 1, 1, 0, 250));
      send_sample(make_sample(150, 50, 2501, 1, 1, 0, 250));
      send_sample(make_sample(150, 50, 2200, 1, 0, 0, 250));
   endtask

   // critical holds relays and source, the mode goes to emergency
   task automatic test_critical_freeze();
      set_pacing(2);
      send_sample(make_sample(150, 100, 2300, 1, 1, 0, 250));
      send_sample(make_sample(150, 100, 1000, 1, 1, 1, 250));
      send_sample(make_sample(0, 0, 0, 0, 0, 1, 0));
   endtask

   // bonus threshold, temperature knee and clamping
   task automatic test_efficiency_terms();
      set_pacing(0);
      send_sample(make_sample(129, 100, 2300, 1, 1, 0, 350));
      send_sample(make_sample(130, 100, 2300, 1, 1, 0, 351));
      send_sample(make_sample(130, 100, 2300, 1, 1, 0, 2047));
      send_sample(make_sample(130, 100, 2300, 1, 1, 0, -2048));
      send_sample(make_sample(4095, 4095, 4095, 1, 1, 1, -1));
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(130, 100, 2300, 1, 1, 0, -400));
   endtask

   task automatic run_random_phase(input cfg_type c);
      apply_config(c);
      set_pacing($urandom_range(0, 3));
      repeat (PHASE_ITEMS) send_sample(random_sample());
   endtask

   // random traffic under default, extreme, inverted and random register sets
   task automatic test_register_sweeps();
      cfg_type c;
      c = default_cfg();
      c.auto_enable = 1'b1;
      run_random_phase(c);
      run_random_phase(default_cfg());
      c = '0;
      c.auto_enable = 1'b1;
      run_random_phase(c);
      c = '1;
      run_random_phase(c);
      // wide windows, hot knee
      c = '0;
      c.auto_enable = 1'b1;
      c.solar_volt_max = 12'hFFF;
      c.grid_volt_max = 12'hFFF;
      c.bonus_volt = 12'd2048;
      c.temp_knee = 12'h7FF;
      run_random_phase(c);
      // solar window inverted, coldest knee
      c = default_cfg();
      c.auto_enable = 1'b1;
      c.solar_volt_min = 12'd300;
      c.solar_volt_max = 12'd100;
      c.temp_knee = 12'h800;
      run_random_phase(c);
      run_random_phase(random_cfg());
      run_random_phase(random_cfg());
   endtask

   // receiver stalls of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, stall_max - 1);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void compare_field(input string label, input logic [EFF_W-1:0] want,
                                         input logic [EFF_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
   endfunction

   // result word checker
   always @(posedge clock) begin : check_selection
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.solar_relay = rsp_tdata[0];
         got.grid_relay = rsp_tdata[1];
         got.op_mode = mode_type'(rsp_tdata[3:2]);
         got.active_source = source_type'(rsp_tdata[5:4]);
         got.efficiency = rsp_tdata[15:6];
         selections_seen++;
         if (expected_selections.size() == 0) begin
            mismatch_count++;
            $display("%0t: result word %h with none expected", $time, rsp_tdata);
         end else begin
            want = expected_selections.pop_front();
            compare_field("solar_relay", want.solar_relay, got.solar_relay);
            compare_field("grid_relay", want.grid_relay, got.grid_relay);
            compare_field("op_mode", want.op_mode, got.op_mode);
            compare_field("active_source", want.active_source, got.active_source);
            compare_field("efficiency", want.efficiency, got.efficiency);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words still expected", $time, expected_selections.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      shadow_cfg = default_cfg();
      relay_state.solar_on = 1'b0;
      relay_state.grid_on = 1'b1;
      relay_state.source = SRC_GRID;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_state();
      test_auto_rules();
      test_critical_freeze();
      test_efficiency_terms();
      test_register_sweeps();
      wait_idle();

      $display("%0d sample words sent, %0d result words checked, %0d register writes",
               samples_sent, selections_seen, config_writes);
      $display("covered mode and relay rules, critical hold, window edges, efficiency clamps");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/sgss_pkg.sv
sv/sgss_decide.sv
sv/solar_grid_source_selector.sv
tb/testbench.sv
